// ===== rtl/segtree_pkg.sv =====
// Shared types and constants for the segment tree range-maximum block.
// No dependencies; every other rtl file except segtree_ram refers to it by scoped names.
package segtree_pkg;

  // Table size and derived widths
  localparam int MAX_ENTRIES = 1024;
  localparam int POS_W       = $clog2(MAX_ENTRIES + 1);   // entry index, 1..MAX_ENTRIES
  localparam int TREE_DEPTH  = 2 * MAX_ENTRIES;           // node 1 is the root
  localparam int NODE_W      = $clog2(TREE_DEPTH);        // node address
  localparam int VAL_W       = 32;                        // stored node maximum
  localparam int IN_VAL_W    = 31;                        // request value
  localparam int FUNC_W      = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Result for an empty range: -(2^30)
  localparam logic [VAL_W-1:0] EMPTY_MAX = VAL_W'(-(64'sd1 <<< 30));

  // Register map (word index)
  localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_RAISE = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Node memory access from the walker
  typedef struct packed {
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== rtl/segtree_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module segtree_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/segtree_cfg.sv =====
// APB-style configuration register file: holds entry_count.
// Uses segtree_pkg for widths and the register map.
module segtree_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [segtree_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [segtree_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [segtree_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready,
  output logic [segtree_pkg::POS_W-1:0]      entry_count
);

  logic [segtree_pkg::POS_W-1:0] entry_count_r;
  logic [segtree_pkg::POS_W-1:0] entry_count_nxt;
  logic [segtree_pkg::POS_W-1:0] wr_val;
  logic                          wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready &&
                  (paddr[2] == segtree_pkg::REG_ENTRY_COUNT);
  assign wr_val = pwdata[segtree_pkg::POS_W-1:0];

  // zero reads as one, above the table size saturates
  always_comb begin
    entry_count_nxt = entry_count_r;
    if (wr_hit) begin
      if (wr_val == '0) begin
        entry_count_nxt = segtree_pkg::POS_W'(1);
      end else if (wr_val > segtree_pkg::POS_W'(segtree_pkg::MAX_ENTRIES)) begin
        entry_count_nxt = segtree_pkg::POS_W'(segtree_pkg::MAX_ENTRIES);
      end else begin
        entry_count_nxt = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= segtree_pkg::POS_W'(1);
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  assign prdata = (paddr[2] == segtree_pkg::REG_ENTRY_COUNT) ?
                  segtree_pkg::CFG_DATA_W'(entry_count_r) : '0;
  assign entry_count = entry_count_r;

endmodule

// ===== rtl/segtree_walk.sv =====
// Tree walker: descends the segment tree one level per cycle, reads nodes
// from the node memory and writes refreshed maxima back. Uses segtree_pkg.
module segtree_walk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [segtree_pkg::FUNC_W-1:0]   in_func,
  input  logic [segtree_pkg::POS_W-1:0]    in_position_low,
  input  logic [segtree_pkg::POS_W-1:0]    in_position_high,
  input  logic [segtree_pkg::IN_VAL_W-1:0] in_value,
  input  logic [segtree_pkg::POS_W-1:0]    entry_count,
  output segtree_pkg::mem_req_t            mem_req,
  input  logic [segtree_pkg::VAL_W-1:0]    mem_rdata,
  output logic                             out_valid,
  output logic [segtree_pkg::VAL_W-1:0]    out_range_max
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_QDESC  = 8'b0000_0010,  // query: common path above the split
    S_QLEFT  = 8'b0000_0100,  // query: left boundary path
    S_QRIGHT = 8'b0000_1000,  // query: right boundary path
    S_QDRAIN = 8'b0001_0000,  // query: fold last read, emit
    S_UDESC  = 8'b0010_0000,  // update: find leaf
    S_ULEAF  = 8'b0100_0000,  // raise: old leaf value arrives
    S_UUP    = 8'b1000_0000   // update: refresh ancestors
  } state_t;

  state_t state_r, state_nxt;

  logic [segtree_pkg::POS_W-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [segtree_pkg::NODE_W-1:0] p_r, p_nxt;
  logic [segtree_pkg::POS_W-1:0]  svl_r, svl_nxt, svr_r, svr_nxt;
  logic [segtree_pkg::NODE_W-1:0] svp_r, svp_nxt;
  logic [segtree_pkg::POS_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [segtree_pkg::VAL_W-1:0]  cur_r, cur_nxt;
  logic [segtree_pkg::VAL_W-1:0]  acc_r, acc_nxt;
  logic                           raise_r, raise_nxt;
  logic                           rd_pend_r, rd_pend_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [segtree_pkg::VAL_W-1:0]  out_max_r, out_max_nxt;

  logic [segtree_pkg::POS_W:0]    sum;
  logic [segtree_pkg::POS_W-1:0]  mid;
  logic [segtree_pkg::NODE_W-1:0] lchild, rchild, parent, sibling, parent_sib;
  logic [segtree_pkg::VAL_W-1:0]  acc_fold, cur_up, leaf_raised, in_val_ext;
  logic                           lo_ok, hi_ok;
  segtree_pkg::func_t             func;

  assign func       = segtree_pkg::func_t'(in_func);
  assign sum        = {1'b0, l_r} + {1'b0, r_r};
  assign mid        = sum[segtree_pkg::POS_W:1];
  assign lchild     = {p_r[segtree_pkg::NODE_W-2:0], 1'b0};
  assign rchild     = {p_r[segtree_pkg::NODE_W-2:0], 1'b1};
  assign parent     = p_r >> 1;
  assign sibling    = p_r ^ segtree_pkg::NODE_W'(1);
  assign parent_sib = parent ^ segtree_pkg::NODE_W'(1);
  assign in_val_ext = segtree_pkg::VAL_W'(in_value);

  assign acc_fold    = (rd_pend_r && (mem_rdata > acc_r)) ? mem_rdata : acc_r;
  assign cur_up      = (mem_rdata > cur_r) ? mem_rdata : cur_r;
  assign leaf_raised = (mem_rdata > cur_r) ? mem_rdata : cur_r;

  assign lo_ok = (in_position_low != '0) && (in_position_low <= entry_count);
  assign hi_ok = (in_position_high != '0) && (in_position_high <= entry_count);

  always_comb begin
    state_nxt     = state_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    p_nxt         = p_r;
    svl_nxt       = svl_r;
    svr_nxt       = svr_r;
    svp_nxt       = svp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_fold;
    raise_nxt     = raise_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_max_nxt   = out_max_r;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          lo_nxt  = in_position_low;
          hi_nxt  = in_position_high;
          l_nxt   = segtree_pkg::POS_W'(1);
          r_nxt   = entry_count;
          p_nxt   = segtree_pkg::NODE_W'(1);
          cur_nxt = in_val_ext;
          acc_nxt = '0;
          case (func)
            segtree_pkg::FUNC_SET, segtree_pkg::FUNC_RAISE: begin
              raise_nxt = (func == segtree_pkg::FUNC_RAISE);
              if (lo_ok) begin
                state_nxt = S_UDESC;
              end
            end
            segtree_pkg::FUNC_QUERY: begin
              if (lo_ok && hi_ok) begin
                if (in_position_low > in_position_high) begin
                  out_valid_nxt = 1'b1;
                  out_max_nxt   = segtree_pkg::EMPTY_MAX;
                end else begin
                  state_nxt = S_QDESC;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_QDESC: begin
        if (((lo_r <= l_r) && (hi_r >= r_r)) || (l_r == r_r)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_r;
          rd_pend_nxt     = 1'b1;
          state_nxt       = S_QDRAIN;
        end else if (hi_r <= mid) begin
          r_nxt = mid;
          p_nxt = lchild;
        end else if (lo_r > mid) begin
          l_nxt = mid + segtree_pkg::POS_W'(1);
          p_nxt = rchild;
        end else begin
          // split: park the right branch, walk the left one first
          svl_nxt   = mid + segtree_pkg::POS_W'(1);
          svr_nxt   = r_r;
          svp_nxt   = rchild;
          r_nxt     = mid;
          p_nxt     = lchild;
          state_nxt = S_QLEFT;
        end
      end

      S_QLEFT: begin
        // range reaches past this node on the right
        if ((lo_r <= l_r) || (l_r == r_r)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_r;
          rd_pend_nxt     = 1'b1;
          l_nxt           = svl_r;
          r_nxt           = svr_r;
          p_nxt           = svp_r;
          state_nxt       = S_QRIGHT;
        end else if (lo_r <= mid) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rchild;
          rd_pend_nxt     = 1'b1;
          r_nxt           = mid;
          p_nxt           = lchild;
        end else begin
          l_nxt = mid + segtree_pkg::POS_W'(1);
          p_nxt = rchild;
        end
      end

      S_QRIGHT: begin
        // range reaches past this node on the left
        if ((hi_r >= r_r) || (l_r == r_r)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_r;
          rd_pend_nxt     = 1'b1;
          state_nxt       = S_QDRAIN;
        end else if (hi_r > mid) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = lchild;
          rd_pend_nxt     = 1'b1;
          l_nxt           = mid + segtree_pkg::POS_W'(1);
          p_nxt           = rchild;
        end else begin
          r_nxt = mid;
          p_nxt = lchild;
        end
      end

      S_QDRAIN: begin
        out_valid_nxt = 1'b1;
        out_max_nxt   = acc_fold;
        state_nxt     = S_IDLE;
      end

      S_UDESC: begin
        if (l_r == r_r) begin
          if (raise_r) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = p_r;
            state_nxt       = S_ULEAF;
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = p_r;
            mem_req.wr_data = cur_r;
            if (p_r == segtree_pkg::NODE_W'(1)) begin
              state_nxt = S_IDLE;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = sibling;
              state_nxt       = S_UUP;
            end
          end
        end else if (lo_r <= mid) begin
          r_nxt = mid;
          p_nxt = lchild;
        end else begin
          l_nxt = mid + segtree_pkg::POS_W'(1);
          p_nxt = rchild;
        end
      end

      S_ULEAF: begin
        cur_nxt         = leaf_raised;
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = p_r;
        mem_req.wr_data = leaf_raised;
        if (p_r == segtree_pkg::NODE_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = sibling;
          state_nxt       = S_UUP;
        end
      end

      S_UUP: begin
        // sibling data is in; parent gets the larger, and the parent's
        // sibling is fetched in the same cycle (never a path node)
        cur_nxt         = cur_up;
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = parent;
        mem_req.wr_data = cur_up;
        p_nxt           = parent;
        if (parent == segtree_pkg::NODE_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = parent_sib;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    p_r       <= p_nxt;
    svl_r     <= svl_nxt;
    svr_r     <= svr_nxt;
    svp_r     <= svp_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    cur_r     <= cur_nxt;
    acc_r     <= acc_nxt;
    raise_r   <= raise_nxt;
    out_max_r <= out_max_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_max = out_max_r;

endmodule

// ===== rtl/segment_tree_range_max.sv =====
// Top level of the range-maximum block: config register, tree walker and node RAM.
// Uses segtree_pkg, segtree_cfg, segtree_walk and segtree_ram.
// A set or raise holds busy until its walk is done; a query strobes its result in the cycle
// after its last busy cycle. Rejected requests never raise busy; an empty range strobes the
// next cycle. One request at a time. Sync active-low reset idles the walker, entry_count = 1;
// node RAM is not cleared.
module segment_tree_range_max (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic [segtree_pkg::FUNC_W-1:0]     in_func,
  input  logic [segtree_pkg::POS_W-1:0]      in_position_low,
  input  logic [segtree_pkg::POS_W-1:0]      in_position_high,
  input  logic [segtree_pkg::IN_VAL_W-1:0]   in_value,
  // result channel, one-cycle strobe
  output logic                               out_valid,
  output logic signed [segtree_pkg::VAL_W-1:0] out_range_max,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [segtree_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [segtree_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [segtree_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);

  logic [segtree_pkg::POS_W-1:0] entry_count;
  segtree_pkg::mem_req_t         mem_req;
  logic [segtree_pkg::VAL_W-1:0] mem_rdata;
  logic [segtree_pkg::VAL_W-1:0] range_max;

  // entry_count register; the user must make writes only while idle; the block does not enforce this
  segtree_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .entry_count (entry_count)
  );

  // Walker: node index p, children 2p and 2p+1, root covers 1..entry_count.
  // Queries split, if the range straddles a midpoint, into a left and right
  // boundary path and fold node reads into a running max; updates descend to
  // the leaf, then climb, reading each sibling and writing the refreshed parent.
  segtree_walk u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_position_low  (in_position_low),
    .in_position_high (in_position_high),
    .in_value         (in_value),
    .entry_count      (entry_count),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_range_max    (range_max)
  );

  // Node store: one maximum per tree node, undefined until written
  segtree_ram #(
    .WIDTH (segtree_pkg::VAL_W),
    .DEPTH (segtree_pkg::TREE_DEPTH)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rdata)
  );

  assign out_range_max = $signed(range_max);

endmodule

// ===== rtl/segtree_chk.sv =====
// Port-level checker for segment_tree_range_max, attached by bind.
// Uses segtree_pkg for field widths and request codes.
module segtree_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [segtree_pkg::FUNC_W-1:0]   in_func,
  input logic                             out_valid
);

  // results only show up once the walk is over
  a_no_result_while_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy
  ) else $error("result strobe while busy");

  // set, raise and unknown codes never produce a result
  a_update_no_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func != segtree_pkg::FUNC_QUERY)) |=> !out_valid
  ) else $error("result after a non-query request");

  // a walk starting cannot coincide with a result
  a_start_walk_quiet: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid
  ) else $error("result in first walk cycle");

  // reset leaves the block idle and quiet
  a_reset_idle: assert property (
    @(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!busy && !out_valid)
  ) else $error("not idle after reset");

endmodule

bind segment_tree_range_max segtree_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_func   (in_func),
  .out_valid (out_valid)
);

// ===== test/segment_tree_range_max_tb.sv =====
// Self-checking testbench for segment_tree_range_max: directed table, then random phases.
// Predicts range maxima with its own tree model and checks every result strobe.
// Depends on rtl/segtree_pkg.sv and rtl/segment_tree_range_max.sv.
`timescale 1ns / 1ps

module segment_tree_range_max_tb;

  // Predictor keeps the same node numbering as the block: root is node 1,
  // children of p are 2p and 2p+1. Nodes past the end read as zero.
  localparam int TREE_SLOTS    = 4 * segtree_pkg::MAX_ENTRIES;
  // Wait long enough for the longest request at full table size, with margin on top.
  localparam int SETTLE_CYCLES = 2 * 10 + 10;
  localparam int N_SCRIPT      = 26;
  localparam int N_PHASES      = 7;

  typedef enum {ROW_REQ, ROW_CFG, ROW_FILL} row_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_BOTH} idle_mode_t;

  // One line of the directed script. ROW_CFG uses data as the register word,
  // ROW_FILL sets every entry of the current count to a random value.
  typedef struct {
    row_kind_t                        kind;
    segtree_pkg::func_t               func;
    logic [segtree_pkg::POS_W-1:0]    lo;
    logic [segtree_pkg::POS_W-1:0]    hi;
    logic [31:0]                      data;
    bit                               typed;
    logic [segtree_pkg::VAL_W-1:0]    want;
  } script_row_t;

  typedef struct {
    logic [31:0] count_word;
    idle_mode_t  idle;
    int          requests;
  } phase_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [segtree_pkg::FUNC_W-1:0]       in_func = '0;
  logic [segtree_pkg::POS_W-1:0]        in_position_low = '0;
  logic [segtree_pkg::POS_W-1:0]        in_position_high = '0;
  logic [segtree_pkg::IN_VAL_W-1:0]     in_value = '0;
  logic                                 out_valid;
  logic signed [segtree_pkg::VAL_W-1:0] out_range_max;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [segtree_pkg::CFG_ADDR_W-1:0]   paddr = '0;
  logic [segtree_pkg::CFG_DATA_W-1:0]   pwdata = '0;
  logic [segtree_pkg::CFG_DATA_W-1:0]   prdata;
  logic                                 pready;

  // Predictor state: stored node maxima and the entry count in force.
  logic signed [segtree_pkg::VAL_W-1:0] node_max [0:TREE_SLOTS-1];
  logic [segtree_pkg::POS_W-1:0]        entry_count_q;

  // Expected range maxima, oldest first.
  logic [segtree_pkg::VAL_W-1:0]        pending_range_max [$];

  int fail_count   = 0;
  int n_accepted   = 0;
  int n_queries    = 0;
  int n_compared   = 0;
  int n_settings   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_tree_range_max dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_position_low  (in_position_low),
    .in_position_high (in_position_high),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_range_max    (out_range_max),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic signed [segtree_pkg::VAL_W-1:0] node_get(int p);
    return (p < TREE_SLOTS) ? node_max[p] : '0;
  endfunction

  function automatic void node_put(int p, logic signed [segtree_pkg::VAL_W-1:0] v);
    if (p < TREE_SLOTS) node_max[p] = v;
  endfunction

  // Walk down to the leaf, write or raise it, then refresh the path upward.
  function automatic void tree_update(int pos, logic signed [segtree_pkg::VAL_W-1:0] v,
                                      bit raise_op);
    int l, r, p, m, depth, i;
    int path [0:31];
    logic signed [segtree_pkg::VAL_W-1:0] a, b;
    l = 1;
    r = entry_count_q;
    p = 1;
    depth = 0;
    while (l != r && p < TREE_SLOTS) begin
      path[depth] = p;
      depth++;
      m = (l + r) >> 1;
      if (pos <= m) begin
        r = m;
        p = 2 * p;
      end else begin
        l = m + 1;
        p = 2 * p + 1;
      end
    end
    if (!raise_op || v > node_get(p)) node_put(p, v);
    for (i = depth - 1; i >= 0; i--) begin
      a = node_get(2 * path[i]);
      b = node_get(2 * path[i] + 1);
      node_put(path[i], (a > b) ? a : b);
    end
  endfunction

  // Range maximum over lo..hi (lo <= hi) with an explicit stack of segments.
  function automatic logic signed [segtree_pkg::VAL_W-1:0] tree_range_max(int lo, int hi);
    int seg_l [0:63];
    int seg_r [0:63];
    int seg_p [0:63];
    int sp, l, r, p, m;
    logic signed [segtree_pkg::VAL_W-1:0] best, v;
    best = $signed(segtree_pkg::EMPTY_MAX);
    seg_l[0] = 1;
    seg_r[0] = entry_count_q;
    seg_p[0] = 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      l = seg_l[sp];
      r = seg_r[sp];
      p = seg_p[sp];
      if ((lo <= l && hi >= r) || l == r || p >= TREE_SLOTS) begin
        v = node_get(p);
        if (v > best) best = v;
      end else begin
        m = (l + r) >> 1;
        if (lo <= m) begin
          seg_l[sp] = l;
          seg_r[sp] = m;
          seg_p[sp] = 2 * p;
          sp++;
        end
        if (hi > m) begin
          seg_l[sp] = m + 1;
          seg_r[sp] = r;
          seg_p[sp] = 2 * p + 1;
          sp++;
        end
      end
    end
    return best;
  endfunction

  // Applies one accepted request; returns 1 when the block owes a result.
  function automatic bit apply_request(segtree_pkg::func_t f, int lo, int hi,
                                       logic signed [segtree_pkg::VAL_W-1:0] v,
                                       output logic [segtree_pkg::VAL_W-1:0] res);
    int cnt;
    cnt = entry_count_q;
    res = '0;
    case (f)
      segtree_pkg::FUNC_SET, segtree_pkg::FUNC_RAISE: begin
        if (lo != 0 && lo <= cnt) tree_update(lo, v, f == segtree_pkg::FUNC_RAISE);
        return 1'b0;
      end
      segtree_pkg::FUNC_QUERY: begin
        if (lo == 0 || lo > cnt || hi == 0 || hi > cnt) return 1'b0;
        res = (lo > hi) ? segtree_pkg::EMPTY_MAX : tree_range_max(lo, hi);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Extremes, small values (so raises go both ways) and full-range values.
  function automatic logic [segtree_pkg::IN_VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? {segtree_pkg::IN_VAL_W{1'b1}} : '0;
      1:       return segtree_pkg::IN_VAL_W'($urandom_range(255));
      default: return segtree_pkg::IN_VAL_W'($urandom);
    endcase
  endfunction

  // In-range index, biased toward both ends of the table.
  function automatic int pick_pos(int cnt);
    case ($urandom_range(7))
      0:       return 1;
      1:       return cnt;
      default: return $urandom_range(cnt, 1);
    endcase
  endfunction

  // Index the block must ignore: zero or past the entry count.
  function automatic int pick_bad_pos(int cnt);
    if ($urandom_range(3) == 0) return 0;
    return $urandom_range(2047, cnt + 1);
  endfunction

  // Presents one request and holds it until the edge that accepts it.
  // Acceptance is judged from busy sampled mid-cycle, so no race with the edge.
  task automatic issue_request(segtree_pkg::func_t f,
                               logic [segtree_pkg::POS_W-1:0] lo,
                               logic [segtree_pkg::POS_W-1:0] hi,
                               logic [segtree_pkg::IN_VAL_W-1:0] v, bit typed,
                               logic [segtree_pkg::VAL_W-1:0] want);
    bit taken;
    logic [segtree_pkg::VAL_W-1:0] predicted;
    start            <= 1'b1;
    in_func          <= f;
    in_position_low  <= lo;
    in_position_high <= hi;
    in_value         <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    n_accepted++;
    if (apply_request(f, lo, hi, {1'b0, v}, predicted)) begin
      n_queries++;
      pending_range_max.push_back(typed ? want : predicted);
    end
  endtask

  // Sender gap: geometric with the given percent per cycle, plus an
  // occasional long hold so gaps land on every stage of a tree walk.
  task automatic idle_gap(int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    if (pct > 0 && $urandom_range(4) == 0) n += $urandom_range(40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain: all results in, then let a trailing update finish before going on.
  task automatic settle();
    bit free;
    start <= 1'b0;
    while (pending_range_max.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    free = 1'b0;
    while (!free) begin
      @(negedge clk);
      free = !busy;
      @(posedge clk);
    end
  endtask

  // Register write (setup + access), then a read back of the clamped count.
  task automatic write_entry_count(logic [31:0] word);
    logic [segtree_pkg::CFG_ADDR_W-1:0] addr;
    logic [segtree_pkg::CFG_DATA_W-1:0] got;
    int cnt;
    addr = {segtree_pkg::REG_ENTRY_COUNT, 2'b00};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Zero means one, anything past the table size means the table size.
    cnt = word[segtree_pkg::POS_W-1:0];
    if (cnt == 0) cnt = 1;
    if (cnt > segtree_pkg::MAX_ENTRIES) cnt = segtree_pkg::MAX_ENTRIES;
    entry_count_q = segtree_pkg::POS_W'(cnt);
    n_settings++;
    @(posedge clk);
    psel  <= 1'b1;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== segtree_pkg::CFG_DATA_W'(entry_count_q)) begin
      $display("%0t: entry_count read back: expected %0d, actual %0d",
               $time, entry_count_q, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the strobe lasts one cycle, so sample it mid-cycle.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic [segtree_pkg::VAL_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_range_max.size() == 0) begin
        $display("%0t: range_max result with no request pending: expected none, actual %0d",
                 $time, out_range_max);
        fail_count++;
      end else begin
        want = pending_range_max.pop_front();
        n_compared++;
        if (out_range_max !== want) begin
          $display("%0t: range_max mismatch: expected %0d, actual %0d",
                   $time, $signed(want), out_range_max);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    script_row_t        script [0:N_SCRIPT-1];
    phase_t             phases [0:N_PHASES-1];
    int                 i, k, done, pct, cnt, lo, hi, sel;
    segtree_pkg::func_t f;
    bit                 counted;

    // Directed script. Starts at the reset count of one entry: a leaf must
    // be set before anything reads it. The fill at full size writes every
    // node of the largest tree, so later count changes never read an
    // unwritten node, and stale maxima under a new shape are read as stored.
    script[0]  = '{ROW_REQ,  segtree_pkg::FUNC_SET,   11'd1,    11'd1,
                   32'h7FFF_FFFF, 1'b0, '0};
    script[1]  = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1,
                   32'd0, 1'b1, 32'h7FFF_FFFF};
    script[2]  = '{ROW_REQ,  segtree_pkg::FUNC_SET,   11'd1,    11'd1,
                   32'd0, 1'b0, '0};
    script[3]  = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1,
                   32'd0, 1'b1, 32'd0};
    script[4]  = '{ROW_REQ,  segtree_pkg::FUNC_RAISE, 11'd1,    11'd1,
                   32'd5, 1'b0, '0};
    script[5]  = '{ROW_REQ,  segtree_pkg::FUNC_RAISE, 11'd1,    11'd1,
                   32'd3, 1'b0, '0};
    script[6]  = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1,
                   32'd0, 1'b1, 32'd5};
    // out of range index, all index bits high: ignored
    script[7]  = '{ROW_REQ,  segtree_pkg::FUNC_SET,   11'd2047, 11'd1,
                   32'd9, 1'b0, '0};
    script[8]  = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd2047,
                   32'd0, 1'b0, '0};
    script[9]  = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd0,    11'd1,
                   32'd0, 1'b0, '0};
    // unused code: ignored
    script[10] = '{ROW_REQ,  segtree_pkg::FUNC_NONE,  11'd1,    11'd1,
                   32'd0, 1'b0, '0};
    // all register bits high: clamps to the table size
    script[11] = '{ROW_CFG,  segtree_pkg::FUNC_NONE,  11'd0,    11'd0,
                   32'hFFFF_FFFF, 1'b0, '0};
    script[12] = '{ROW_FILL, segtree_pkg::FUNC_NONE,  11'd0,    11'd0,
                   32'd0, 1'b0, '0};
    script[13] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1024,
                   32'd0, 1'b0, '0};
    script[14] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1024, 11'd1024,
                   32'd0, 1'b0, '0};
    // empty range
    script[15] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd600,  11'd7,
                   32'd0, 1'b1, segtree_pkg::EMPTY_MAX};
    script[16] = '{ROW_REQ,  segtree_pkg::FUNC_RAISE, 11'd1024, 11'd1,
                   32'h7FFF_FFFF, 1'b0, '0};
    script[17] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1024,
                   32'd0, 1'b1, 32'h7FFF_FFFF};
    script[18] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1024, 11'd1024,
                   32'd0, 1'b1, 32'h7FFF_FFFF};
    script[19] = '{ROW_REQ,  segtree_pkg::FUNC_SET,   11'd0,    11'd1,
                   32'd1, 1'b0, '0};
    script[20] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1025,
                   32'd0, 1'b0, '0};
    script[21] = '{ROW_REQ,  segtree_pkg::FUNC_RAISE, 11'd1025, 11'd1,
                   32'd1, 1'b0, '0};
    // zero count clamps to one; root now reads the old full-tree maximum
    script[22] = '{ROW_CFG,  segtree_pkg::FUNC_NONE,  11'd0,    11'd0,
                   32'd0, 1'b0, '0};
    script[23] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd1,    11'd1,
                   32'd0, 1'b0, '0};
    script[24] = '{ROW_CFG,  segtree_pkg::FUNC_NONE,  11'd0,    11'd0,
                   32'd5, 1'b0, '0};
    script[25] = '{ROW_REQ,  segtree_pkg::FUNC_QUERY, 11'd2,    11'd4,
                   32'd0, 1'b0, '0};

    // Random phases: entry counts from one to full size, sender idling
    // none / 51% / 10%. The result side has no backpressure to apply.
    phases[0] = '{32'd1024,      IDLE_NONE,   150};
    phases[1] = '{32'd7,         IDLE_SENDER, 100};
    phases[2] = '{32'hFFFF_F800, IDLE_BOTH,   60};   // low bits zero: count of one
    phases[3] = '{32'd1000,      IDLE_NONE,   150};
    phases[4] = '{32'd2,         IDLE_SENDER, 100};
    phases[5] = '{32'd513,       IDLE_BOTH,   140};
    phases[6] = '{32'd33,        IDLE_SENDER, 150};

    for (i = 0; i < TREE_SLOTS; i++) node_max[i] = '0;
    entry_count_q = segtree_pkg::POS_W'(1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_SCRIPT; i++) begin
      case (script[i].kind)
        ROW_REQ: begin
          issue_request(script[i].func, script[i].lo, script[i].hi,
                        script[i].data[segtree_pkg::IN_VAL_W-1:0], script[i].typed,
                        script[i].want);
        end
        ROW_CFG: begin
          settle();
          write_entry_count(script[i].data);
        end
        default: begin
          cnt = entry_count_q;
          for (k = 1; k <= cnt; k++)
            issue_request(segtree_pkg::FUNC_SET, segtree_pkg::POS_W'(k),
                          segtree_pkg::POS_W'(1), pick_value(), 1'b0, '0);
        end
      endcase
    end

    for (i = 0; i < N_PHASES; i++) begin
      settle();
      write_entry_count(phases[i].count_word);
      cnt = entry_count_q;
      case (phases[i].idle)
        IDLE_SENDER: pct = 51;
        IDLE_BOTH:   pct = 10;
        default:     pct = 0;
      endcase
      done = 0;
      while (done < phases[i].requests) begin
        idle_gap(pct);
        lo = pick_pos(cnt);
        hi = pick_pos(cnt);
        sel = $urandom_range(99);
        counted = 1'b1;
        if (sel < 5) begin
          // Noise: requests the block must drop without a trace.
          counted = 1'b0;
          case ($urandom_range(3))
            0: begin
              f  = segtree_pkg::FUNC_NONE;
              lo = $urandom_range(2047);
              hi = $urandom_range(2047);
            end
            1: begin
              f  = $urandom_range(1) ? segtree_pkg::FUNC_SET : segtree_pkg::FUNC_RAISE;
              lo = pick_bad_pos(cnt);
            end
            2: begin
              f  = segtree_pkg::FUNC_QUERY;
              hi = pick_bad_pos(cnt);
            end
            default: begin
              f  = segtree_pkg::FUNC_QUERY;
              lo = pick_bad_pos(cnt);
            end
          endcase
        end else if (sel < 40) begin
          f = segtree_pkg::FUNC_SET;
        end else if (sel < 65) begin
          f = segtree_pkg::FUNC_RAISE;
        end else begin
          f = segtree_pkg::FUNC_QUERY;
          if ($urandom_range(9) == 0) begin
            lo = 1;
            hi = cnt;
          end
        end
        issue_request(f, segtree_pkg::POS_W'(lo), segtree_pkg::POS_W'(hi), pick_value(),
                      1'b0, '0);
        if (counted) done++;
      end
    end

    settle();

    $display("Run covered %0d accepted requests (%0d with a result) over %0d entry-count writes;",
             n_accepted, n_queries, n_settings);
    $display("%0d range maxima compared, %0d failures.", n_compared, fail_count);
    if (fail_count == 0 && pending_range_max.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results still pending.", pending_range_max.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
